// ===== src/xkb_pkg.sv =====
// Shared types, constants and the base64 alphabet function for the XOR-key base64 encoder.
package xkb_pkg;

   localparam int unsigned DATA_WIDTH      = 8;
   localparam int unsigned CHAR_WIDTH      = 7;
   localparam int unsigned KEY_LOW_WIDTH   = 64;
   localparam int unsigned KEY_HIGH_WIDTH  = 32;
   localparam int unsigned KEY_LEN_WIDTH   = 4;
   localparam int unsigned CSR_DATA_WIDTH  = 64;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned GROUP_CHARS     = 4;
   localparam int unsigned GROUP_IDX_WIDTH = 2;

   // Longest key in use; longer programmed lengths saturate here.
   localparam logic [KEY_LEN_WIDTH-1:0] KEY_LEN_MAX = 4'd12;
   localparam logic [KEY_LEN_WIDTH-1:0] KEY_LEN_MIN = 4'd1;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_KEY_LOW  = 2'd0,
      CSR_KEY_HIGH = 2'd1,
      CSR_KEY_LEN  = 2'd2
   } csr_index_type;

   // Byte position within a three-byte base64 group.
   localparam logic [1:0] GRP_FIRST  = 2'd0;
   localparam logic [1:0] GRP_SECOND = 2'd1;
   localparam logic [1:0] GRP_THIRD  = 2'd2;

   // ASCII codes used by the alphabet.
   localparam logic [CHAR_WIDTH-1:0] ASCII_UPPER_A = 7'h41;
   localparam logic [CHAR_WIDTH-1:0] ASCII_LOWER_A = 7'h61;
   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO    = 7'h30;
   localparam logic [CHAR_WIDTH-1:0] ASCII_PLUS    = 7'h2B;
   localparam logic [CHAR_WIDTH-1:0] ASCII_SLASH   = 7'h2F;
   localparam logic [CHAR_WIDTH-1:0] ASCII_PAD     = 7'h3D;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] data_byte;
      logic                  last_byte;
   } req_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] out_char;
      logic                  last_char;
   } rsp_type;

   // Characters produced by one request, sent in order from index zero.
   typedef struct packed {
      logic [GROUP_CHARS-1:0][CHAR_WIDTH-1:0] chars;
      logic [GROUP_IDX_WIDTH-1:0]             last_idx;
      logic                                   last;
   } grp_type;

   function automatic logic [CHAR_WIDTH-1:0] b64_char(input logic [5:0] v);
      logic [CHAR_WIDTH-1:0] c;
      logic [CHAR_WIDTH-1:0] w;
      w = {1'b0, v};
      if (v < 6'd26) begin
         c = ASCII_UPPER_A + w;
      end else if (v < 6'd52) begin
         c = ASCII_LOWER_A + (w - 7'd26);
      end else if (v < 6'd62) begin
         c = ASCII_ZERO + (w - 7'd52);
      end else if (v == 6'd62) begin
         c = ASCII_PLUS;
      end else begin
         c = ASCII_SLASH;
      end
      return c;
   endfunction

endpackage

// ===== src/xkb_encode.sv =====
// Key registers, key and group position state, and the XOR and base64 split of one request.
module xkb_encode (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [xkb_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [xkb_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   input  logic                                 step,
   input  xkb_pkg::req_type                     item,
   output xkb_pkg::grp_type                     grp
);

   logic [xkb_pkg::KEY_LOW_WIDTH-1:0]  key_low_ff,  key_low_in;
   logic [xkb_pkg::KEY_HIGH_WIDTH-1:0] key_high_ff, key_high_in;
   logic [xkb_pkg::KEY_LEN_WIDTH-1:0]  key_len_ff,  key_len_in;
   logic [xkb_pkg::KEY_LEN_WIDTH-1:0]  key_pos_ff,  key_pos_in;
   logic [1:0]                         grp_pos_ff,  grp_pos_in;
   logic [5:0]                         left_ff,     left_in;

   logic [15:0][xkb_pkg::DATA_WIDTH-1:0] key_arr;
   logic [xkb_pkg::KEY_LEN_WIDTH-1:0]    len_eff;
   logic [xkb_pkg::KEY_LEN_WIDTH-1:0]    pos_cur;
   logic [xkb_pkg::KEY_LEN_WIDTH:0]      pos_inc;
   logic [xkb_pkg::KEY_LEN_WIDTH-1:0]    pos_next;
   logic [xkb_pkg::DATA_WIDTH-1:0]       xb;
   logic [1:0]                           gp_after;
   logic [5:0]                           left_after;

   // Configuration writes.
   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      key_len_in  = key_len_ff;
      if (csr_we) begin
         unique case (csr_index)
            xkb_pkg::CSR_KEY_LOW:  key_low_in  = csr_wdata;
            xkb_pkg::CSR_KEY_HIGH: key_high_in = csr_wdata[xkb_pkg::KEY_HIGH_WIDTH-1:0];
            xkb_pkg::CSR_KEY_LEN:  key_len_in  = csr_wdata[xkb_pkg::KEY_LEN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Key bytes beyond the two registers read as zero.
   assign key_arr = {32'h0, key_high_ff, key_low_ff};

   always_comb begin
      if (key_len_ff == '0) begin
         len_eff = xkb_pkg::KEY_LEN_MIN;
      end else if (key_len_ff > xkb_pkg::KEY_LEN_MAX) begin
         len_eff = xkb_pkg::KEY_LEN_MAX;
      end else begin
         len_eff = key_len_ff;
      end
      // A position left over from a longer key restarts at the first byte.
      pos_cur  = (key_pos_ff >= len_eff) ? '0 : key_pos_ff;
      pos_inc  = {1'b0, pos_cur} + 5'd1;
      pos_next = (pos_inc >= {1'b0, len_eff}) ? '0 : pos_inc[xkb_pkg::KEY_LEN_WIDTH-1:0];
      xb       = item.data_byte ^ key_arr[pos_cur];
   end

   always_comb begin
      grp.chars    = {xkb_pkg::GROUP_CHARS{xkb_pkg::ASCII_PAD}};
      grp.last_idx = 2'd0;
      grp.last     = item.last_byte;
      case (grp_pos_ff)
         xkb_pkg::GRP_SECOND: begin
            grp.chars[0] = xkb_pkg::b64_char(left_ff | {2'b00, xb[7:4]});
            left_after   = {xb[3:0], 2'b00};
            gp_after     = xkb_pkg::GRP_THIRD;
         end
         xkb_pkg::GRP_THIRD: begin
            grp.chars[0] = xkb_pkg::b64_char(left_ff | {4'b0000, xb[7:6]});
            grp.chars[1] = xkb_pkg::b64_char(xb[5:0]);
            grp.last_idx = 2'd1;
            left_after   = '0;
            gp_after     = xkb_pkg::GRP_FIRST;
         end
         default: begin
            grp.chars[0] = xkb_pkg::b64_char(xb[7:2]);
            left_after   = {xb[1:0], 4'b0000};
            gp_after     = xkb_pkg::GRP_SECOND;
         end
      endcase

      key_pos_in = key_pos_ff;
      grp_pos_in = grp_pos_ff;
      left_in    = left_ff;
      if (step) begin
         key_pos_in = pos_next;
         grp_pos_in = gp_after;
         left_in    = left_after;
         if (item.last_byte) begin
            key_pos_in = '0;
            grp_pos_in = xkb_pkg::GRP_FIRST;
            left_in    = '0;
         end
      end

      // Flush: the pending bits and padding follow the ordinary characters.
      if (item.last_byte) begin
         if (gp_after == xkb_pkg::GRP_SECOND) begin
            grp.chars[1] = xkb_pkg::b64_char(left_after);
            grp.last_idx = 2'd3;
         end else if (gp_after == xkb_pkg::GRP_THIRD) begin
            grp.chars[1] = xkb_pkg::b64_char(left_after);
            grp.last_idx = 2'd2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         key_len_ff  <= xkb_pkg::KEY_LEN_MIN;
         key_pos_ff  <= '0;
         grp_pos_ff  <= xkb_pkg::GRP_FIRST;
         left_ff     <= '0;
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
         key_len_ff  <= key_len_in;
         key_pos_ff  <= key_pos_in;
         grp_pos_ff  <= grp_pos_in;
         left_ff     <= left_in;
      end
   end

`ifndef ASSERT_OFF
   a_grp_pos_range: assert property (@(posedge clock) disable iff (reset)
      grp_pos_ff != 2'd3)
      else $error("group position reached an unused code");

   a_key_pos_range: assert property (@(posedge clock) disable iff (reset)
      key_pos_ff < xkb_pkg::KEY_LEN_MAX)
      else $error("key position beyond the longest key");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (step && item.last_byte) |=> (key_pos_ff == '0 && grp_pos_ff == xkb_pkg::GRP_FIRST
                                    && left_ff == '0))
      else $error("final byte did not return the encoder state to its start");
`endif

endmodule

// ===== src/xkb_serial.sv =====
// Character group register and one-character output register with its handshake.
module xkb_serial (
   input  logic              clock,
   input  logic              reset,
   input  logic              load_valid,
   input  xkb_pkg::grp_type  load_grp,
   output logic              load_ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output xkb_pkg::rsp_type  rsp_data
);

   logic                                 grp_valid_ff, grp_valid_in;
   xkb_pkg::grp_type                     grp_ff,       grp_in;
   logic [xkb_pkg::GROUP_IDX_WIDTH-1:0]  grp_idx_ff,   grp_idx_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   xkb_pkg::rsp_type                     rsp_data_ff,  rsp_data_in;

   logic out_move;
   logic grp_done;
   logic load;

   assign out_move   = grp_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign grp_done   = out_move && (grp_idx_ff == grp_ff.last_idx);
   assign load_ready = !grp_valid_ff || grp_done;
   assign load       = load_valid && load_ready;

   always_comb begin
      grp_valid_in = load || (grp_valid_ff && !grp_done);
      grp_in       = load ? load_grp : grp_ff;
      if (load) begin
         grp_idx_in = '0;
      end else if (out_move) begin
         grp_idx_in = grp_idx_ff + 2'd1;
      end else begin
         grp_idx_in = grp_idx_ff;
      end

      rsp_valid_in = out_move || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = rsp_data_ff;
      if (out_move) begin
         rsp_data_in.out_char  = grp_ff.chars[grp_idx_ff];
         rsp_data_in.last_char = grp_ff.last && (grp_idx_ff == grp_ff.last_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_valid_ff <= 1'b0;
         grp_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         grp_valid_ff <= grp_valid_in;
         grp_idx_ff   <= grp_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff      <= grp_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_idx_in_group: assert property (@(posedge clock) disable iff (reset)
      grp_valid_ff |-> (grp_idx_ff <= grp_ff.last_idx))
      else $error("character index ran past the end of its group");

   a_group_held: assert property (@(posedge clock) disable iff (reset)
      (out_move && !grp_done) |=> (grp_valid_ff
                                   && grp_idx_ff == 2'($past(grp_idx_ff) + 2'd1)))
      else $error("group dropped before its last character was sent");
`endif

endmodule

// ===== src/xor_key_base64_encoder.sv =====
// Top level of the repeating-key XOR and streaming base64 encoder.
// A request's first character reaches rsp_valid through the input register, the group
// register and the result register. A request yields one to four characters, which
// leave one at a time through the single-character result register; the group register
// takes the next request as the last character of the current one moves out.
// Reset is synchronous and active high: valid flags and encoder state clear, key bytes
// clear to zero and the key length returns to one.
module xor_key_base64_encoder (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  xkb_pkg::req_type                    req_data,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output xkb_pkg::rsp_type                    rsp_data,

   input  logic                                csr_we,
   input  logic [xkb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [xkb_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   // Input register: a request is captured here whenever the slot is free or is
   // being emptied in the same cycle, so requests can arrive back to back.
   logic             in_valid_ff, in_valid_in;
   xkb_pkg::req_type in_data_ff,  in_data_in;

   logic             req_accept;
   logic             in_advance;
   logic             grp_ready;
   xkb_pkg::grp_type grp;

   // The request moves on, and the key and group state step, once the group
   // register can take its characters.
   assign in_advance = in_valid_ff && grp_ready;
   assign req_stall  = in_valid_ff && !grp_ready;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = req_accept || (in_valid_ff && !in_advance);
      in_data_in  = req_accept ? req_data : in_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
   end

   // XOR with the current key byte and split into base64 characters, with the
   // padding appended when the request carries the final byte.
   xkb_encode u_encode (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (in_advance),
      .item      (in_data_ff),
      .grp       (grp)
   );

   // Holds the characters of one request and sends them one per cycle through
   // the result register while the receiver does not stall.
   xkb_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .load_valid (in_valid_ff),
      .load_grp   (grp),
      .load_ready (grp_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the repeating-key XOR and streaming base64 encoder.
module tb;
   import xkb_pkg::*;

   // Cycles without any accepted request or character before the run is abandoned.
   // The longest honest quiet spell is the deliberate receiver hold-off below.
   localparam int unsigned QUIET_LIMIT     = 2000;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   // Settling time after the last character.
   localparam int unsigned SETTLE_CYCLES   = 4;
   localparam int unsigned PHASE_COUNT     = 4;
   localparam int unsigned BLOCKS_PER_PHASE = 4;
   localparam int unsigned BYTES_PER_BLOCK = 30;

   // Tracks the key registers and the encoder state as the block should see them, and
   // holds the characters that accepted requests still owe the result channel.
   class encoded_char_tracker;
      logic [KEY_LOW_WIDTH-1:0]  key_low;
      logic [KEY_HIGH_WIDTH-1:0] key_high;
      logic [KEY_LEN_WIDTH-1:0]  key_len;
      int unsigned               key_pos;
      logic [1:0]                group_pos;
      logic [5:0]                carry_bits;
      rsp_type                   due_chars[$];
      int unsigned               failures;
      int unsigned               chars_seen;
      string                     alphabet;

      function new();
         alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
         failures = 0;
         chars_seen = 0;
         clear();
      endfunction

      function void clear();
         key_low   = '0;
         key_high  = '0;
         key_len   = KEY_LEN_MIN;
         key_pos   = 0;
         group_pos = GRP_FIRST;
         carry_bits = '0;
         due_chars.delete();
      endfunction

      function void write_key_register(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] v);
         case (idx)
            CSR_KEY_LOW:  key_low  = v[KEY_LOW_WIDTH-1:0];
            CSR_KEY_HIGH: key_high = v[KEY_HIGH_WIDTH-1:0];
            CSR_KEY_LEN:  key_len  = v[KEY_LEN_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned outstanding();
         return due_chars.size();
      endfunction

      function void owe(logic [5:0] sextet);
         rsp_type c;
         c.out_char  = CHAR_WIDTH'(alphabet[sextet]);
         c.last_char = 1'b0;
         due_chars.push_back(c);
      endfunction

      function void owe_pad();
         rsp_type c;
         c.out_char  = ASCII_PAD;
         c.last_char = 1'b0;
         due_chars.push_back(c);
      endfunction

      // Works out the characters that one accepted request produces.
      function void absorb_byte(req_type item);
         int unsigned len;
         int unsigned pos;
         logic [7:0]  key_byte;
         logic [7:0]  plain;
         len = key_len;
         if (len == 0) len = 1;
         if (len > KEY_LEN_MAX) len = KEY_LEN_MAX;
         // A length lowered mid-message can leave the position past the end.
         pos = (key_pos >= len) ? 0 : key_pos;
         if (pos < 8) key_byte = key_low[8*pos +: 8];
         else if (pos < 12) key_byte = key_high[8*(pos-8) +: 8];
         else key_byte = 8'h00;
         plain = item.data_byte ^ key_byte;
         pos++;
         key_pos = (pos >= len) ? 0 : pos;

         case (group_pos)
            GRP_SECOND: begin
               owe(carry_bits | {2'b00, plain[7:4]});
               carry_bits = {plain[3:0], 2'b00};
               group_pos = GRP_THIRD;
            end
            GRP_THIRD: begin
               owe(carry_bits | {4'b0000, plain[7:6]});
               owe(plain[5:0]);
               carry_bits = '0;
               group_pos = GRP_FIRST;
            end
            default: begin
               owe(plain[7:2]);
               carry_bits = {plain[1:0], 4'b0000};
               group_pos = GRP_SECOND;
            end
         endcase

         if (item.last_byte) begin
            if (group_pos == GRP_SECOND) begin
               owe(carry_bits);
               owe_pad();
               owe_pad();
            end else if (group_pos == GRP_THIRD) begin
               owe(carry_bits);
               owe_pad();
            end
            due_chars[$].last_char = 1'b1;
            key_pos = 0;
            group_pos = GRP_FIRST;
            carry_bits = '0;
         end
      endfunction

      function void check_char(rsp_type got);
         rsp_type want;
         chars_seen++;
         if (due_chars.size() == 0) begin
            failures++;
            $display("%0t: unexpected character, expected none, got %02h last %0b",
                     $time, got.out_char, got.last_char);
            return;
         end
         want = due_chars.pop_front();
         if (got.out_char !== want.out_char || got.last_char !== want.last_char) begin
            failures++;
            $display("%0t: character %0d mismatch, expected %02h last %0b, got %02h last %0b",
                     $time, chars_seen, want.out_char, want.last_char,
                     got.out_char, got.last_char);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   logic    req_valid;
   logic    req_stall;
   req_type req_data;

   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   encoded_char_tracker tracker;

   // Idling odds, in percent, for the current phase of the run.
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;

   // The main sequence raises this; the receiver then counts out the hold-off itself.
   bit          hold_off_request;
   int unsigned hold_left;

   int unsigned quiet_cycles;
   int unsigned msg_left;

   xor_key_base64_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver decides its stall at every falling edge. A pending hold-off request
   // overrides the random odds for a long stretch, so that the block backs up and
   // eventually stalls the request side as well.
   always @(negedge clock) begin
      if (hold_off_request) begin
         hold_left = HOLD_OFF_CYCLES;
         hold_off_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Characters are taken at the rising edge, where the values settled in the previous
   // half cycle are still visible.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_char(rsp_data);
   end

   // Watchdog: any accepted request or character restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Offers one request, with a random idle gap in front of it, and holds it steady
   // until it is accepted. Valid is left high so that the next request follows on
   // without a bubble.
   task automatic offer(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_data.data_byte <= 8'($urandom_range(255));
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      tracker.absorb_byte(item);
      @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] value, input logic last);
      req_type item;
      item.data_byte = value;
      item.last_byte = last;
      offer(item);
   endtask

   // Next byte of a random message. Most messages are short, so that the flush and
   // padding paths come round often, but some run long enough to wrap a long key.
   task automatic send_stream_byte();
      req_type item;
      if (msg_left == 0) begin
         msg_left = ($urandom_range(99) < 80) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      end
      item.data_byte = 8'($urandom_range(255));
      item.last_byte = (msg_left == 1);
      msg_left--;
      offer(item);
   endtask

   // Stops offering and waits until every owed character has come out, then lets the
   // block settle before anything else happens.
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic put_csr(input csr_index_type idx, input logic [CSR_DATA_WIDTH-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      tracker.write_key_register(idx, v);
      @(negedge clock);
   endtask

   // Writes the whole key. The upper bits of the narrower registers carry junk, which
   // the block must ignore.
   task automatic load_key(input logic [63:0] low, input logic [63:0] high_word,
                           input logic [63:0] len_word);
      put_csr(CSR_KEY_LOW, low);
      put_csr(CSR_KEY_HIGH, high_word);
      put_csr(CSR_KEY_LEN, len_word);
      csr_we <= 1'b0;
   endtask

   // A random key for one block of the run. Lengths of zero and above twelve are
   // written now and then to exercise the clamping.
   task automatic load_random_key();
      logic [63:0] low;
      logic [63:0] high_word;
      logic [63:0] len_word;
      case ($urandom_range(7))
         0:       low = '1;
         1:       low = '0;
         default: low = {$urandom, $urandom};
      endcase
      high_word = ($urandom_range(7) == 0) ? '1 : {$urandom, $urandom};
      len_word = {$urandom, $urandom};
      case ($urandom_range(5))
         0:       len_word[3:0] = 4'd0;
         1:       len_word[3:0] = KEY_LEN_MIN;
         2:       len_word[3:0] = KEY_LEN_MAX;
         3:       len_word[3:0] = 4'($urandom_range(13, 15));
         default: len_word[3:0] = 4'($urandom_range(1, 12));
      endcase
      load_key(low, high_word, len_word);
   endtask

   initial begin
      tracker = new();
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_KEY_LOW;
      csr_wdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_request = 1'b0;
      hold_left = 0;
      quiet_cycles = 0;
      msg_left = 0;

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, with the reset key (a single zero byte), so the bytes pass
      // through unchanged. A lone byte ends with two pad characters, two bytes with
      // one, and a full group with none; the group FB EF BE gives the second-last
      // alphabet character and the all-ones groups the last.
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFB, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBE, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      drain();

      // Twelve distinct key bytes, then nine bytes of an unfinished message so that the
      // key position stands at nine.
      load_key(64'hF7E6_D5C4_B3A2_9180, 64'hDEAD_BEEF_0C1B_2A39, 64'h0000_0000_0000_00FC);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h0F, 1'b0);
      send_byte(8'hF0, 1'b0);
      send_byte(8'h3C, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(8'h81, 1'b0);
      drain();

      // Shortening the key now leaves the position beyond its end: the next byte must
      // fall back to key byte zero and the message carries on from there.
      load_key(64'hF7E6_D5C4_B3A2_9180, 64'hDEAD_BEEF_0C1B_2A39, 64'h0000_0000_0000_00F3);
      send_byte(8'h7E, 1'b0);
      send_byte(8'h01, 1'b1);
      drain();

      // Random part. Each phase has its own idling odds; within a phase the key is
      // rewritten every block, often in the middle of a message, which is allowed as
      // long as nothing is owed at the time of the write.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 48; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 48; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
         endcase
         for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
            drain();
            load_random_key();
            // In the first phase the receiver holds off for a long stretch while
            // requests keep coming, so the block fills up and stalls its input.
            if (phase == 0 && blk == 1) hold_off_request = 1'b1;
            for (int n = 0; n < BYTES_PER_BLOCK; n++) begin
               // Once, the sender pauses until the block has emptied completely.
               if (phase == 1 && blk == 2 && n == BYTES_PER_BLOCK / 2) drain();
               send_stream_byte();
            end
         end
      end

      // Close the message that may still be open.
      while (msg_left != 0) send_stream_byte();

      drain();
      repeat (20) @(negedge clock);
      if (tracker.outstanding() != 0) begin
         $display("%0t: %0d characters expected but never received",
                  $time, tracker.outstanding());
      end
      if (tracker.failures == 0 && tracker.outstanding() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/xkb_pkg.sv
src/xkb_encode.sv
src/xkb_serial.sv
src/xor_key_base64_encoder.sv
test/tb.sv
